// File: hdl/ics_pkg.sv
// shared types, constants and register codes for the infection compartment step
package ics_pkg;

    localparam int PROB_BITS = 16;
    localparam int DRAW_W    = PROB_BITS + 1;
    localparam int PROD_W    = 2 * PROB_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] COMP_S = 3'd0;
    localparam logic [2:0] COMP_E = 3'd1;
    localparam logic [2:0] COMP_T = 3'd2;
    localparam logic [2:0] COMP_D = 3'd3;
    localparam logic [2:0] COMP_A = 3'd4;
    localparam logic [2:0] COMP_U = 3'd5;
    localparam logic [2:0] COMP_P = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_DEATH_PROB      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATENT_DAYS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TREATED_FRAC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TREATED_EXIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISEASE_EXIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATENT_EXIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUBPATENT_EXIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PROPHYLAXIS_EXIT = 3'd7;

    localparam logic [15:0] DAYS_2Y  = 16'd730;
    localparam logic [15:0] DAYS_5Y  = 16'd1825;
    localparam logic [15:0] DAYS_10Y = 16'd3650;
    localparam logic [15:0] DAYS_15Y = 16'd5475;

    localparam logic [7:0] LAT_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]           compartment;
        logic [7:0]           latent_count;
        logic [15:0]          age_days;
        logic [PROB_BITS-1:0] infection_prob;
        logic [PROB_BITS-1:0] clinical_prob;
        logic [PROB_BITS-1:0] death_draw;
        logic [PROB_BITS-1:0] transition_draw;
    } t_req;

    typedef struct packed {
        logic [2:0] next_compartment;
        logic [7:0] next_latent_count;
        logic       died;
        logic       clinical_case;
        logic [1:0] case_age_band;
        logic       case_age_2_to_10;
    } t_res;

    typedef struct packed {
        logic [PROB_BITS-1:0] death_prob;
        logic [7:0]           latent_days;
        logic [PROB_BITS-1:0] treated_fraction;
        logic [PROB_BITS-1:0] treated_exit_prob;
        logic [PROB_BITS-1:0] disease_exit_prob;
        logic [PROB_BITS-1:0] patent_exit_prob;
        logic [PROB_BITS-1:0] subpatent_exit_prob;
        logic [PROB_BITS-1:0] prophylaxis_exit_prob;
    } t_cfg;

    typedef struct packed {
        logic [2:0]           comp;
        logic [7:0]           lat;
        logic                 lat_lt;
        logic [7:0]           lat_inc;
        logic [PROB_BITS-1:0] lam;
        logic [PROB_BITS-1:0] phi;
        logic [DRAW_W-1:0]    r1;
        logic [PROB_BITS-1:0] pf;
        logic [PROB_BITS-1:0] pl;
        logic [PROB_BITS-1:0] pfl;
        logic                 died;
        logic [1:0]           band;
        logic                 flag;
    } t_mid;

endpackage

// File: hdl/infection_compartment_step_top.sv
// top level of the daily infection compartment step
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_req  (t_req)
//   result    out        o_valid / i_stall    o_res  (t_res)
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one request per cycle while o_stall is low, one result per request
// stage one: death test, age band and two products; stage two: third product, latent compare
// and increment; stage three: transition choice into the output register
// each stage holds its valid bit and advances when the one after it is empty or moving
// synchronous active-low reset clears the valid bits and loads the register defaults
module infection_compartment_step_top
    import ics_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_req                  i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_mid mid;
    logic mid_valid;
    logic mid_take;

    ics_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ics_prob_pipe u_prob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .i_take  (mid_take),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    ics_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (mid_valid),
        .i_mid   (mid),
        .o_take  (mid_take),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    a_dead_no_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.died |-> !o_res.clinical_case)
        else $error("death reported with a clinical case");

    a_no_case_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.clinical_case |->
            o_res.case_age_band == 2'd0 && !o_res.case_age_2_to_10)
        else $error("age band set without a clinical case");

    a_case_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.clinical_case |->
            o_res.next_compartment == COMP_T || o_res.next_compartment == COMP_D)
        else $error("clinical case not moved to a treated or diseased compartment");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

// File: hdl/ics_cfg_regs.sv
// configuration register file
module ics_cfg_regs
    import ics_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEATH_PROB:       n_cfg.death_prob            = i_cfg_data;
                REG_LATENT_DAYS:      n_cfg.latent_days           = i_cfg_data[7:0];
                REG_TREATED_FRAC:     n_cfg.treated_fraction      = i_cfg_data;
                REG_TREATED_EXIT:     n_cfg.treated_exit_prob     = i_cfg_data;
                REG_DISEASE_EXIT:     n_cfg.disease_exit_prob     = i_cfg_data;
                REG_PATENT_EXIT:      n_cfg.patent_exit_prob      = i_cfg_data;
                REG_SUBPATENT_EXIT:   n_cfg.subpatent_exit_prob   = i_cfg_data;
                REG_PROPHYLAXIS_EXIT: n_cfg.prophylaxis_exit_prob = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.death_prob            <= 16'd9;
            r_cfg.latent_days           <= 8'd12;
            r_cfg.treated_fraction      <= '0;
            r_cfg.treated_exit_prob     <= '0;
            r_cfg.disease_exit_prob     <= '0;
            r_cfg.patent_exit_prob      <= '0;
            r_cfg.subpatent_exit_prob   <= '0;
            r_cfg.prophylaxis_exit_prob <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/ics_prob_pipe.sv
// first two stages: death test, age band, probability products, latent count compare
module ics_prob_pipe
    import ics_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    input  logic i_take,
    output logic o_valid,
    output t_mid o_mid
);

    logic r_v1;
    logic r_v2;
    t_mid r_s1;
    t_mid r_s2;
    t_mid n_s1;
    t_mid n_s2;
    logic en1;
    logic en2;
    logic [PROD_W-1:0] prod_pf;
    logic [PROD_W-1:0] prod_pl;
    logic [PROD_W-1:0] prod_pfl;
    logic [DRAW_W-1:0] dth1;

    assign en2 = !r_v2 || i_take;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    // stage one
    always_comb begin
        prod_pf = PROD_W'(i_req.clinical_prob) * PROD_W'(i_cfg.treated_fraction);
        prod_pl = PROD_W'(i_req.clinical_prob) * PROD_W'(i_req.infection_prob);
        dth1    = {1'b0, i_req.death_draw} + DRAW_W'(1);
        n_s1         = '0;
        n_s1.comp    = i_req.compartment;
        n_s1.lat     = i_req.latent_count;
        n_s1.lam     = i_req.infection_prob;
        n_s1.phi     = i_req.clinical_prob;
        n_s1.r1      = {1'b0, i_req.transition_draw} + DRAW_W'(1);
        n_s1.pf      = prod_pf[PROD_W-1:PROB_BITS];
        n_s1.pl      = prod_pl[PROD_W-1:PROB_BITS];
        n_s1.died    = dth1 <= {1'b0, i_cfg.death_prob};
        if (i_req.age_days < DAYS_5Y) begin
            n_s1.band = 2'd0;
        end else if (i_req.age_days < DAYS_10Y) begin
            n_s1.band = 2'd1;
        end else if (i_req.age_days < DAYS_15Y) begin
            n_s1.band = 2'd2;
        end else begin
            n_s1.band = 2'd3;
        end
        n_s1.flag = (i_req.age_days >= DAYS_2Y) && (i_req.age_days < DAYS_10Y);
    end

    // stage two
    always_comb begin
        prod_pfl = PROD_W'(r_s1.pf) * PROD_W'(r_s1.lam);
        n_s2         = r_s1;
        n_s2.pfl     = prod_pfl[PROD_W-1:PROB_BITS];
        n_s2.lat_lt  = r_s1.lat < i_cfg.latent_days;
        n_s2.lat_inc = (r_s1.lat < LAT_MAX) ? r_s1.lat + 8'd1 : LAT_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) r_s1 <= n_s1;
        if (en2 && r_v1) r_s2 <= n_s2;
    end

    assign o_valid = r_v2;
    assign o_mid   = r_s2;

endmodule

// File: hdl/ics_decide.sv
// final stage: transition choice and output register
module ics_decide
    import ics_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_mid i_mid,
    output logic o_take,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    logic r_v3;
    t_res r_res;
    t_res n_res;
    logic en3;
    logic clin;
    logic [2:0] nxt;
    logic [7:0] nlat;
    logic [DRAW_W-1:0] sum_patent;
    logic [DRAW_W-1:0] sum_subpatent;

    assign en3    = !r_v3 || !i_stall;
    assign o_take = en3;

    always_comb begin
        sum_patent    = {1'b0, i_mid.pl} + {1'b0, i_cfg.patent_exit_prob};
        sum_subpatent = {1'b0, i_mid.lam} + {1'b0, i_cfg.subpatent_exit_prob};
        nxt  = i_mid.comp;
        nlat = i_mid.lat;
        clin = 1'b0;
        case (i_mid.comp)
            COMP_S: begin
                if (i_mid.r1 <= {1'b0, i_mid.lam}) begin
                    nxt  = COMP_E;
                    nlat = '0;
                end
            end
            COMP_E: begin
                if (i_mid.lat_lt) begin
                    nlat = i_mid.lat_inc;
                end else begin
                    nlat = '0;
                    if (i_mid.r1 <= {1'b0, i_mid.pf}) begin
                        nxt  = COMP_T;
                        clin = 1'b1;
                    end else if (i_mid.r1 <= {1'b0, i_mid.phi}) begin
                        nxt  = COMP_D;
                        clin = 1'b1;
                    end else begin
                        nxt = COMP_A;
                    end
                end
            end
            COMP_T: if (i_mid.r1 <= {1'b0, i_cfg.treated_exit_prob}) nxt = COMP_P;
            COMP_D: if (i_mid.r1 <= {1'b0, i_cfg.disease_exit_prob}) nxt = COMP_A;
            COMP_A: begin
                if (i_mid.r1 <= {1'b0, i_mid.pfl}) begin
                    nxt  = COMP_T;
                    clin = 1'b1;
                end else if (i_mid.r1 <= {1'b0, i_mid.pl}) begin
                    nxt  = COMP_D;
                    clin = 1'b1;
                end else if (i_mid.r1 <= sum_patent) begin
                    nxt = COMP_U;
                end
            end
            COMP_U: begin
                if (i_mid.r1 <= {1'b0, i_mid.pfl}) begin
                    nxt  = COMP_T;
                    clin = 1'b1;
                end else if (i_mid.r1 <= {1'b0, i_mid.pl}) begin
                    nxt  = COMP_D;
                    clin = 1'b1;
                end else if (i_mid.r1 <= {1'b0, i_mid.lam}) begin
                    nxt = COMP_A;
                end else if (i_mid.r1 <= sum_subpatent) begin
                    nxt = COMP_S;
                end
            end
            COMP_P: if (i_mid.r1 <= {1'b0, i_cfg.prophylaxis_exit_prob}) nxt = COMP_S;
            default: ;
        endcase

        n_res = '0;
        if (i_mid.died) begin
            n_res.next_compartment  = i_mid.comp;
            n_res.next_latent_count = i_mid.lat;
            n_res.died              = 1'b1;
        end else begin
            n_res.next_compartment  = nxt;
            n_res.next_latent_count = nlat;
            n_res.clinical_case     = clin;
            n_res.case_age_band     = clin ? i_mid.band : 2'd0;
            n_res.case_age_2_to_10  = clin && i_mid.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && i_valid) r_res <= n_res;
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

// File: dv/tb_infection_compartment_step_top.sv
// self-checking testbench for the daily infection compartment step, with its own predictor
module tb_infection_compartment_step_top
    import ics_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 300;
    localparam int QUIET_ITEMS   = 200;
    localparam int RANDOM_PHASES = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_req                  i_req;
    logic                  o_valid;
    logic                  i_stall;
    t_res                  o_res;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_cfg regs;
    t_res due_results[$];
    int   mismatch_count = 0;
    bit   throttle = 1'b1;

    infection_compartment_step_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_res step_person(input t_req q);
        t_res        res;
        logic [63:0] dth;
        logic [63:0] r;
        logic [63:0] lam;
        logic [63:0] phi;
        logic [63:0] pf;
        logic [63:0] pl;
        logic [63:0] pfl;
        res.next_compartment  = q.compartment;
        res.next_latent_count = q.latent_count;
        res.died              = 1'b0;
        res.clinical_case     = 1'b0;
        res.case_age_band     = 2'd0;
        res.case_age_2_to_10  = 1'b0;
        dth = 64'(q.death_draw) + 64'd1;
        r   = 64'(q.transition_draw) + 64'd1;
        lam = 64'(q.infection_prob);
        phi = 64'(q.clinical_prob);
        if (dth <= 64'(regs.death_prob)) begin
            res.died = 1'b1;
        end else begin
            pf  = (phi * 64'(regs.treated_fraction)) >> PROB_BITS;
            pl  = (phi * lam) >> PROB_BITS;
            pfl = (pf * lam) >> PROB_BITS;
            case (q.compartment)
                COMP_S: begin
                    if (r <= lam) begin
                        res.next_compartment  = COMP_E;
                        res.next_latent_count = 8'd0;
                    end
                end
                COMP_E: begin
                    if (q.latent_count < regs.latent_days) begin
                        res.next_latent_count = (q.latent_count < LAT_MAX) ?
                                                q.latent_count + 8'd1 : LAT_MAX;
                    end else begin
                        res.next_latent_count = 8'd0;
                        if (r <= pf) begin
                            res.next_compartment = COMP_T;
                            res.clinical_case    = 1'b1;
                        end else if (r <= phi) begin
                            res.next_compartment = COMP_D;
                            res.clinical_case    = 1'b1;
                        end else begin
                            res.next_compartment = COMP_A;
                        end
                    end
                end
                COMP_T: begin
                    if (r <= 64'(regs.treated_exit_prob)) res.next_compartment = COMP_P;
                end
                COMP_D: begin
                    if (r <= 64'(regs.disease_exit_prob)) res.next_compartment = COMP_A;
                end
                COMP_A: begin
                    if (r <= pfl) begin
                        res.next_compartment = COMP_T;
                        res.clinical_case    = 1'b1;
                    end else if (r <= pl) begin
                        res.next_compartment = COMP_D;
                        res.clinical_case    = 1'b1;
                    end else if (r <= pl + 64'(regs.patent_exit_prob)) begin
                        res.next_compartment = COMP_U;
                    end
                end
                COMP_U: begin
                    if (r <= pfl) begin
                        res.next_compartment = COMP_T;
                        res.clinical_case    = 1'b1;
                    end else if (r <= pl) begin
                        res.next_compartment = COMP_D;
                        res.clinical_case    = 1'b1;
                    end else if (r <= lam) begin
                        res.next_compartment = COMP_A;
                    end else if (r <= lam + 64'(regs.subpatent_exit_prob)) begin
                        res.next_compartment = COMP_S;
                    end
                end
                COMP_P: begin
                    if (r <= 64'(regs.prophylaxis_exit_prob)) res.next_compartment = COMP_S;
                end
                default: begin
                end
            endcase
            if (res.clinical_case) begin
                if (q.age_days < DAYS_5Y) res.case_age_band = 2'd0;
                else if (q.age_days < DAYS_10Y) res.case_age_band = 2'd1;
                else if (q.age_days < DAYS_15Y) res.case_age_band = 2'd2;
                else res.case_age_band = 2'd3;
                res.case_age_2_to_10 = (q.age_days >= DAYS_2Y) && (q.age_days < DAYS_10Y);
            end
        end
        return res;
    endfunction

    function automatic t_req person(input logic [2:0] comp, input logic [7:0] lat,
                                    input logic [15:0] age, input logic [15:0] lam,
                                    input logic [15:0] phi, input logic [15:0] dd,
                                    input logic [15:0] td);
        t_req q;
        q.compartment     = comp;
        q.latent_count    = lat;
        q.age_days        = age;
        q.infection_prob  = lam;
        q.clinical_prob   = phi;
        q.death_draw      = dd;
        q.transition_draw = td;
        return q;
    endfunction

    function automatic t_req random_person();
        t_req q;
        q.compartment = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        case ($urandom_range(0, 3))
            0: q.latent_count = regs.latent_days;
            1: q.latent_count = regs.latent_days - 8'd1;
            default: q.latent_count = 8'($urandom_range(0, 255));
        endcase
        q.age_days        = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 6000));
        q.infection_prob  = 16'($urandom_range(0, 65535));
        q.clinical_prob   = 16'($urandom_range(0, 65535));
        q.death_draw      = 16'($urandom_range(0, 65535));
        q.transition_draw = $urandom_range(0, 2) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 16383));
        return q;
    endfunction

    function automatic t_cfg random_settings(input int phase);
        t_cfg c;
        case (phase)
            0: c = '0;
            1: c = '1;
            default: begin
                c.death_prob = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                            : 16'($urandom_range(0, 3000));
                c.latent_days = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 15));
                c.treated_fraction      = 16'($urandom_range(0, 65535));
                c.treated_exit_prob     = 16'($urandom_range(0, 65535));
                c.disease_exit_prob     = 16'($urandom_range(0, 65535));
                c.patent_exit_prob      = 16'($urandom_range(0, 65535));
                c.subpatent_exit_prob   = 16'($urandom_range(0, 65535));
                c.prophylaxis_exit_prob = 16'($urandom_range(0, 65535));
            end
        endcase
        return c;
    endfunction

    task automatic send_request(input t_req q);
        int gap;
        if (throttle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= q;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        due_results.push_back(step_person(q));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_DEATH_PROB:       regs.death_prob            = data;
            REG_LATENT_DAYS:      regs.latent_days           = data[7:0];
            REG_TREATED_FRAC:     regs.treated_fraction      = data;
            REG_TREATED_EXIT:     regs.treated_exit_prob     = data;
            REG_DISEASE_EXIT:     regs.disease_exit_prob     = data;
            REG_PATENT_EXIT:      regs.patent_exit_prob      = data;
            REG_SUBPATENT_EXIT:   regs.subpatent_exit_prob   = data;
            REG_PROPHYLAXIS_EXIT: regs.prophylaxis_exit_prob = data;
            default: begin
            end
        endcase
    endtask

    task automatic write_all(input t_cfg c);
        logic [7:0] upper;
        upper = 8'($urandom_range(0, 255));
        write_register(REG_DEATH_PROB, c.death_prob);
        write_register(REG_LATENT_DAYS, {upper, c.latent_days});
        write_register(REG_TREATED_FRAC, c.treated_fraction);
        write_register(REG_TREATED_EXIT, c.treated_exit_prob);
        write_register(REG_DISEASE_EXIT, c.disease_exit_prob);
        write_register(REG_PATENT_EXIT, c.patent_exit_prob);
        write_register(REG_SUBPATENT_EXIT, c.subpatent_exit_prob);
        write_register(REG_PROPHYLAXIS_EXIT, c.prophylaxis_exit_prob);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // result side: check each accepted result and, while throttled, stall in random bursts
    initial begin
        t_res exp_res;
        int   stall_left;
        i_stall    = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request pending, expected none actual %h",
                             $time, o_res);
                end else begin
                    exp_res = due_results.pop_front();
                    check_field("next_compartment", 8'(exp_res.next_compartment),
                                8'(o_res.next_compartment));
                    check_field("next_latent_count", exp_res.next_latent_count,
                                o_res.next_latent_count);
                    check_field("died", 8'(exp_res.died), 8'(o_res.died));
                    check_field("clinical_case", 8'(exp_res.clinical_case),
                                8'(o_res.clinical_case));
                    check_field("case_age_band", 8'(exp_res.case_age_band),
                                8'(o_res.case_age_band));
                    check_field("case_age_2_to_10", 8'(exp_res.case_age_2_to_10),
                                8'(o_res.case_age_2_to_10));
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (throttle && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                stall_left = $urandom_range(1, 8) - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic test_reset_values();
        send_request(person(COMP_S, 8'd0, 16'd100, 16'h0100, 16'h0000, 16'd8, 16'd0));
        send_request(person(COMP_S, 8'd0, 16'd100, 16'h0100, 16'h0000, 16'd9, 16'd0));
        send_request(person(COMP_E, 8'd12, 16'd4000, 16'h0100, 16'hFFFF, 16'hFFFF, 16'd0));
        settle();
    endtask

    task automatic test_directed_cases();
        t_cfg c;
        c.death_prob            = 16'd9;
        c.latent_days           = 8'd12;
        c.treated_fraction      = 16'h8000;
        c.treated_exit_prob     = 16'h4000;
        c.disease_exit_prob     = 16'h4000;
        c.patent_exit_prob      = 16'h4000;
        c.subpatent_exit_prob   = 16'h4000;
        c.prophylaxis_exit_prob = 16'h4000;
        write_all(c);
        // lam 0x2000, phi 0x8000: treated share 0x4000, clinical 0x1000, treated clinical 0x800
        send_request(person(COMP_S, 8'd5, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h1FFF));
        send_request(person(COMP_S, 8'd5, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h2000));
        send_request(person(COMP_E, 8'd3, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        send_request(person(COMP_E, 8'd12, 16'd0, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        send_request(person(COMP_E, 8'd12, 16'd729, 16'h2000, 16'h8000, 16'hFFFF, 16'h4000));
        send_request(person(COMP_E, 8'd200, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'hFFFF));
        send_request(person(COMP_T, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        send_request(person(COMP_T, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'hFFFF));
        send_request(person(COMP_D, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h3FFF));
        send_request(person(COMP_A, 8'd7, 16'd730, 16'h2000, 16'h8000, 16'hFFFF, 16'h07FF));
        send_request(person(COMP_A, 8'd7, 16'd1824, 16'h2000, 16'h8000, 16'hFFFF, 16'h0FFF));
        send_request(person(COMP_A, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h4FFF));
        send_request(person(COMP_A, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h5000));
        send_request(person(COMP_U, 8'd7, 16'd1825, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        send_request(person(COMP_U, 8'd7, 16'd3649, 16'h2000, 16'h8000, 16'hFFFF, 16'h0FFF));
        send_request(person(COMP_U, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h1FFF));
        send_request(person(COMP_U, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h5FFF));
        send_request(person(COMP_U, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'hFFFF));
        send_request(person(COMP_P, 8'd7, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        // unused code 7 keeps its code and latent count
        send_request(person(3'd7, 8'd77, 16'd10, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        send_request(person(COMP_E, 8'd12, 16'd10, 16'h2000, 16'h8000, 16'd8, 16'h0000));
        send_request(person(COMP_U, 8'd7, 16'd3650, 16'h2000, 16'h8000, 16'd9, 16'h0000));
        send_request(person(COMP_A, 8'd7, 16'd5474, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        send_request(person(COMP_E, 8'd12, 16'd5475, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        send_request(person(COMP_U, 8'd7, 16'hFFFF, 16'h2000, 16'h8000, 16'hFFFF, 16'h0000));
        settle();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_all(random_settings(phase));
            repeat (PHASE_ITEMS) send_request(random_person());
            settle();
        end
    endtask

    task automatic test_unthrottled();
        throttle = 1'b0;
        write_all(random_settings(2));
        repeat (QUIET_ITEMS) send_request(random_person());
        settle();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        regs.death_prob            = 16'd9;
        regs.latent_days           = 8'd12;
        regs.treated_fraction      = 16'd0;
        regs.treated_exit_prob     = 16'd0;
        regs.disease_exit_prob     = 16'd0;
        regs.patent_exit_prob      = 16'd0;
        regs.subpatent_exit_prob   = 16'd0;
        regs.prophylaxis_exit_prob = 16'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_directed_cases();
        test_random_settings();
        test_unthrottled();
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: infection_compartment_step_top.f
hdl/ics_pkg.sv
hdl/ics_cfg_regs.sv
hdl/ics_prob_pipe.sv
hdl/ics_decide.sv
hdl/infection_compartment_step_top.sv
dv/tb_infection_compartment_step_top.sv
